// ----- design/tcpq_pkg.sv -----
package tcpq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL_W     = 10;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] CLASS_LOW     = 2'd0;
  localparam logic [1:0] CLASS_NORMAL  = 2'd1;
  localparam logic [1:0] CLASS_HIGH    = 2'd2;
  localparam logic [1:0] CLASS_INVALID = 2'd3;

  localparam logic [1:0] REG_STOP_ACCEPTING   = 2'd0;
  localparam logic [1:0] REG_HIGH_BURST_LIMIT = 2'd1;

  localparam logic [3:0] BURST_LIMIT_RESET = 4'd3;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_STOPPING  = 3'd2,
    ST_BAD_CLASS = 3'd3,
    ST_POPPED    = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] func;
    logic [31:0] arg;
  } task_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

// ----- design/tcpq_fifo.sv -----
module tcpq_fifo
  import tcpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctl_t  ctl,
  input  task_t      wr_task,
  output task_t      rd_task,
  output fifo_stat_t stat
);

  task_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_FULL);

  // ring storage, read data registered and held between pops
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_task;
    end
    if (ctl.pop) begin
      rd_task <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (ctl.pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/three_class_priority_task_queue.sv -----
// Three-class task queue: low, normal and high FIFOs of QUEUE_DEPTH tasks each
// (16-bit function id plus 32-bit argument). Every request (push or pop) gives
// exactly one result. One request is taken per clock unless a stalled result
// keeps the last one in the input register; its result is presented when it
// moves from the input register into the result register, which also loads
// the registered read port of the task memories.
// Pops choose high while its run of consecutive grants is below
// high_burst_limit, else normal (clearing the run), else low, else high.
// Pushes are refused while stop_accepting is set, for class 3, or when the
// class FIFO is full. No clearing pass after reset: entries are only read
// after they have been written. Configuration is taken at any time but should
// only be changed while the block is idle.
module three_class_priority_task_queue
  import tcpq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,

  input  logic         in_valid,
  output logic         in_ready,
  input  logic         kind,
  input  logic [1:0]   task_class,
  input  logic [15:0]  task_function,
  input  logic [31:0]  task_argument,

  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   status,
  output logic [1:0]   granted_class,
  output logic [15:0]  granted_function,
  output logic [31:0]  granted_argument,
  output logic [9:0]   pending_total,

  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  // configuration registers
  logic       stop_accepting;
  logic [3:0] high_burst_limit;

  // input register
  logic        req_valid;
  logic        req_kind;
  logic [1:0]  req_class;
  task_t       req_task;

  // result register (task payload lives in the fifo read ports)
  status_t      res_status;
  logic [1:0]   res_class;
  logic         res_popped;
  logic [TOTAL_W-1:0] total;

  logic [3:0] high_run;
  logic [3:0] high_run_next;

  logic         advance;
  fifo_ctl_t    ctl_low, ctl_normal, ctl_high;
  fifo_stat_t   stat_low, stat_normal, stat_high;
  task_t        rd_low, rd_normal, rd_high;
  status_t      status_next;
  logic [1:0]   class_next;
  logic         popped_next;
  logic         push_ok;
  logic         class_full;
  logic         high_pref;
  task_t        rd_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_accepting   <= 1'b0;
      high_burst_limit <= BURST_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STOP_ACCEPTING:   stop_accepting   <= cfg_data[0];
        REG_HIGH_BURST_LIMIT: high_burst_limit <= cfg_data;
        default: ;  // unknown register, ignored
      endcase
    end
  end

  // the request in the input register moves on when the result slot frees up
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_kind      <= kind;
      req_class     <= task_class;
      req_task.func <= task_function;
      req_task.arg  <= task_argument;
    end
  end

  // full flag of the addressed class
  always_comb begin
    unique case (req_class)
      CLASS_LOW:    class_full = stat_low.full;
      CLASS_NORMAL: class_full = stat_normal.full;
      CLASS_HIGH:   class_full = stat_high.full;
      default:      class_full = 1'b0;
    endcase
  end

  assign high_pref = !stat_high.empty && (high_run < high_burst_limit);

  // decision for the request in the input register
  always_comb begin
    ctl_low       = '0;
    ctl_normal    = '0;
    ctl_high      = '0;
    status_next   = ST_EMPTY;
    class_next    = CLASS_LOW;
    popped_next   = 1'b0;
    high_run_next = high_run;
    push_ok       = 1'b0;
    if (req_kind == KIND_PUSH) begin
      priority if (stop_accepting) begin
        status_next = ST_STOPPING;
      end else if (req_class == CLASS_INVALID) begin
        status_next = ST_BAD_CLASS;
      end else if (class_full) begin
        status_next = ST_FULL;
      end else begin
        status_next     = ST_PUSHED;
        push_ok         = 1'b1;
        ctl_low.push    = advance && (req_class == CLASS_LOW);
        ctl_normal.push = advance && (req_class == CLASS_NORMAL);
        ctl_high.push   = advance && (req_class == CLASS_HIGH);
      end
    end else begin
      priority if (high_pref) begin
        status_next   = ST_POPPED;
        class_next    = CLASS_HIGH;
        popped_next   = 1'b1;
        high_run_next = high_run + 1'b1;
        ctl_high.pop  = advance;
      end else if (!stat_normal.empty) begin
        status_next    = ST_POPPED;
        class_next     = CLASS_NORMAL;
        popped_next    = 1'b1;
        high_run_next  = '0;
        ctl_normal.pop = advance;
      end else if (!stat_low.empty) begin
        status_next = ST_POPPED;
        class_next  = CLASS_LOW;
        popped_next = 1'b1;
        ctl_low.pop = advance;
      end else if (!stat_high.empty) begin
        // fallback: high grant outside the burst, run untouched
        status_next  = ST_POPPED;
        class_next   = CLASS_HIGH;
        popped_next  = 1'b1;
        ctl_high.pop = advance;
      end else begin
        status_next = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      high_run  <= '0;
      total     <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        high_run  <= high_run_next;
        if (push_ok) begin
          total <= total + 1'b1;
        end else if (popped_next) begin
          total <= total - 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status <= status_next;
      res_class  <= class_next;
      res_popped <= popped_next;
    end
  end

  tcpq_fifo u_fifo_low (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_low),
    .wr_task (req_task),
    .rd_task (rd_low),
    .stat    (stat_low)
  );

  tcpq_fifo u_fifo_normal (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_normal),
    .wr_task (req_task),
    .rd_task (rd_normal),
    .stat    (stat_normal)
  );

  tcpq_fifo u_fifo_high (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_high),
    .wr_task (req_task),
    .rd_task (rd_high),
    .stat    (stat_high)
  );

  // granted payload comes from the read port of the class that was popped
  always_comb begin
    unique case (res_class)
      CLASS_LOW:    rd_sel = rd_low;
      CLASS_NORMAL: rd_sel = rd_normal;
      CLASS_HIGH:   rd_sel = rd_high;
      default:      rd_sel = '0;
    endcase
  end

  assign status           = res_status;
  assign granted_class    = res_class;
  assign granted_function = res_popped ? rd_sel.func : 16'd0;
  assign granted_argument = res_popped ? rd_sel.arg  : 32'd0;
  assign pending_total    = total;

endmodule

// ----- verif/three_class_priority_task_queue_tb.sv -----
`timescale 1ns / 1ps

module three_class_priority_task_queue_tb;
  import tcpq_pkg::*;

  // results come out when a request moves from the input register to the result register
  localparam int RESULT_LATENCY = 1;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 3;

  // register indexes with no register behind them
  localparam logic [1:0] REG_UNUSED_A = 2'd2;
  localparam logic [1:0] REG_UNUSED_B = 2'd3;

  // what one request is expected to produce
  typedef struct {
    status_t     status;
    logic [1:0]  cls;
    logic [15:0] func;
    logic [31:0] arg;
    logic [9:0]  total;
  } outcome_t;

  bit          clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [1:0]  task_class;
  logic [15:0] task_function;
  logic [31:0] task_argument;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [1:0]  granted_class;
  logic [15:0] granted_function;
  logic [31:0] granted_argument;
  logic [9:0]  pending_total;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  // mirror of the queue: three ring buffers, their pointers and fill levels
  task_t       mirror_store [3][QUEUE_DEPTH];
  int          mirror_rd [3];
  int          mirror_wr [3];
  int          mirror_fill [3];
  logic [3:0]  mirror_run;
  logic        mirror_stop;
  logic [3:0]  mirror_limit;

  // outcomes of accepted requests, oldest first
  outcome_t    outcome_q [$];

  // idle percentages for the request side and the result side
  int          send_idle_pct;
  int          recv_idle_pct;

  int          error_count;
  int          request_count;
  int          result_count;
  int          status_seen [6];

  three_class_priority_task_queue u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .task_class       (task_class),
    .task_function    (task_function),
    .task_argument    (task_argument),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .granted_class    (granted_class),
    .granted_function (granted_function),
    .granted_argument (granted_argument),
    .pending_total    (pending_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("three_class_priority_task_queue_tb: done, errors");
    $finish;
  end

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // applies one request to the mirror and returns what the block must answer
  function automatic outcome_t apply_request(logic k, logic [1:0] c, logic [15:0] f,
                                             logic [31:0] a);
    outcome_t o;
    int       pick;
    o.status = ST_PUSHED;
    o.cls    = CLASS_LOW;
    o.func   = '0;
    o.arg    = '0;
    if (k == KIND_PUSH) begin
      // stopping wins over a bad class, a bad class over a full one
      if (mirror_stop) begin
        o.status = ST_STOPPING;
      end else if (c == CLASS_INVALID) begin
        o.status = ST_BAD_CLASS;
      end else if (mirror_fill[c] >= QUEUE_DEPTH) begin
        o.status = ST_FULL;
      end else begin
        mirror_store[c][mirror_wr[c]] = '{func: f, arg: a};
        mirror_wr[c] = (mirror_wr[c] + 1) % QUEUE_DEPTH;
        mirror_fill[c]++;
      end
    end else begin
      // high while the run is under the limit, then normal, low, high as fallback
      pick = -1;
      if (mirror_fill[CLASS_HIGH] > 0 && mirror_run < mirror_limit) begin
        pick = CLASS_HIGH;
        mirror_run = mirror_run + 4'd1;
      end else if (mirror_fill[CLASS_NORMAL] > 0) begin
        pick = CLASS_NORMAL;
        mirror_run = '0;
      end else if (mirror_fill[CLASS_LOW] > 0) begin
        pick = CLASS_LOW;
      end else if (mirror_fill[CLASS_HIGH] > 0) begin
        pick = CLASS_HIGH;
      end
      if (pick < 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.status = ST_POPPED;
        o.cls    = pick[1:0];
        o.func   = mirror_store[pick][mirror_rd[pick]].func;
        o.arg    = mirror_store[pick][mirror_rd[pick]].arg;
        mirror_rd[pick] = (mirror_rd[pick] + 1) % QUEUE_DEPTH;
        mirror_fill[pick]--;
      end
    end
    o.total = 10'(mirror_fill[0] + mirror_fill[1] + mirror_fill[2]);
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // result checker: each result against the oldest outstanding outcome
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (status <= ST_EMPTY) status_seen[status]++;
      if (outcome_q.size() == 0) begin
        $error("result with no request outstanding: status 0x%0h", status);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, status);
        check_field("granted_class", want.cls, granted_class);
        check_field("granted_function", want.func, granted_function);
        check_field("granted_argument", want.arg, granted_argument);
        check_field("pending_total", want.total, pending_total);
      end
    end
  end

  // one request: optional idle gap, hold until accepted, then predict.
  // in_valid stays high on return; the next request or wait_idle decides
  task automatic send_request(logic k, logic [1:0] c, logic [15:0] f, logic [31:0] a);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    task_class    <= c;
    task_function <= f;
    task_argument <= a;
    do @(posedge clk); while (!in_ready);
    outcome_q.push_back(apply_request(k, c, f, a));
    request_count++;
  endtask

  task automatic push_task(logic [1:0] c, logic [15:0] f, logic [31:0] a);
    send_request(KIND_PUSH, c, f, a);
  endtask

  // pops carry random junk in the ignored fields
  task automatic pop_task();
    send_request(KIND_POP, 2'($urandom), 16'($urandom), $urandom);
  endtask

  // stop sending, let every result drain, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes happen only with the block idle
  task automatic write_register(logic [1:0] idx, logic [3:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_STOP_ACCEPTING) mirror_stop = data[0];
    else if (idx == REG_HIGH_BURST_LIMIT) mirror_limit = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // empty pop, field extremes, bad class, default burst limit of three
  task automatic test_basic_requests();
    pop_task();
    push_task(CLASS_LOW, 16'h0000, 32'h0000_0000);
    push_task(CLASS_LOW, 16'hFFFF, 32'hFFFF_FFFF);
    push_task(CLASS_NORMAL, 16'h0001, 32'h8000_0000);
    push_task(CLASS_HIGH, 16'h8000, 32'h0000_0001);
    push_task(CLASS_HIGH, 16'h5555, 32'hAAAA_AAAA);
    push_task(CLASS_HIGH, 16'hAAAA, 32'h5555_5555);
    push_task(CLASS_HIGH, 16'h7FFF, 32'h7FFF_FFFF);
    push_task(CLASS_INVALID, 16'hFFFF, 32'hFFFF_FFFF);
    repeat (8) pop_task();
  endtask

  // stopping refuses every push but not pops; unused indexes change nothing
  task automatic test_stop_and_unused_registers();
    push_task(CLASS_NORMAL, 16'h1234, 32'hDEAD_BEEF);
    write_register(REG_STOP_ACCEPTING, 4'h1);
    push_task(CLASS_LOW, 16'h0001, 32'h1);
    push_task(CLASS_HIGH, 16'h0002, 32'h2);
    push_task(CLASS_INVALID, 16'h0003, 32'h3);
    pop_task();
    write_register(REG_STOP_ACCEPTING, 4'hE);
    write_register(REG_UNUSED_A, 4'hF);
    write_register(REG_UNUSED_B, 4'h0);
    pop_task();
    push_task(CLASS_HIGH, 16'hBEEF, 32'h0BAD_F00D);
    pop_task();
  endtask

  // limit of zero: high only as the last resort
  task automatic test_zero_burst_limit();
    write_register(REG_HIGH_BURST_LIMIT, 4'h0);
    push_task(CLASS_HIGH, 16'h0101, 32'h0000_0101);
    push_task(CLASS_LOW, 16'h0202, 32'h0000_0202);
    push_task(CLASS_NORMAL, 16'h0303, 32'h0000_0303);
    push_task(CLASS_HIGH, 16'h0404, 32'h0000_0404);
    repeat (5) pop_task();
  endtask

  // build a run of five at limit 15, then drop the limit under the run
  task automatic test_limit_below_run();
    write_register(REG_HIGH_BURST_LIMIT, 4'hF);
    for (int i = 0; i < 9; i++) push_task(CLASS_HIGH, 16'(16'hA000 + i), $urandom);
    repeat (2) push_task(CLASS_NORMAL, 16'($urandom), $urandom);
    repeat (5) pop_task();
    write_register(REG_HIGH_BURST_LIMIT, 4'h2);
    repeat (7) pop_task();
    write_register(REG_HIGH_BURST_LIMIT, BURST_LIMIT_RESET);
  endtask

  // fill each class past capacity, then drain everything through the wrap
  task automatic test_full_classes();
    for (int c = CLASS_LOW; c <= CLASS_HIGH; c++) begin
      repeat (QUEUE_DEPTH + 1) push_task(c[1:0], 16'($urandom), $urandom);
    end
    repeat (3 * QUEUE_DEPTH + 1) pop_task();
  endtask

  // random mix; each chunk gets fresh registers and a push bias of 70, 50 or 35 percent in turn
  task automatic test_random_traffic(int chunks, int per_chunk);
    int push_pct;
    int pick;
    logic [1:0] c;
    for (int n = 0; n < chunks; n++) begin
      write_register(REG_STOP_ACCEPTING, ($urandom_range(99) < 15) ? 4'h1 : 4'h0);
      write_register(REG_HIGH_BURST_LIMIT, 4'($urandom_range(0, 15)));
      case (n % 3)
        0: push_pct = 70;
        1: push_pct = 50;
        default: push_pct = 35;
      endcase
      repeat (per_chunk) begin
        if ($urandom_range(99) < push_pct) begin
          // high heavy so the burst limit comes into play
          pick = $urandom_range(99);
          if (pick < 5) c = CLASS_INVALID;
          else if (pick < 30) c = CLASS_LOW;
          else if (pick < 55) c = CLASS_NORMAL;
          else c = CLASS_HIGH;
          push_task(c, 16'($urandom), $urandom);
        end else begin
          pop_task();
        end
      end
    end
  endtask

  initial begin
    // every input known from time zero
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = KIND_PUSH;
    task_class    = CLASS_LOW;
    task_function = '0;
    task_argument = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_STOP_ACCEPTING;
    cfg_data      = '0;
    error_count   = 0;
    request_count = 0;
    result_count  = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (mirror_fill[i]) begin
      mirror_rd[i]   = 0;
      mirror_wr[i]   = 0;
      mirror_fill[i] = 0;
    end
    mirror_run    = '0;
    mirror_stop   = 1'b0;
    mirror_limit  = BURST_LIMIT_RESET;

    // first mix: sender mostly busy, receiver stalls a lot
    send_idle_pct = 12;
    recv_idle_pct = 77;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_requests();
    test_stop_and_unused_registers();
    test_zero_burst_limit();
    test_limit_below_run();
    test_full_classes();
    test_random_traffic(6, 25);

    // second mix: sender idles a lot, receiver rarely stalls
    send_idle_pct = 77;
    recv_idle_pct = 12;
    test_random_traffic(6, 25);

    // third mix: full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(6, 25);

    wait_idle();
    if (outcome_q.size() != 0) begin
      $error("%0d outcomes never arrived", outcome_q.size());
      error_count++;
    end

    $display("covered %0d requests (%0d results) under three idle mixes, limits 0 to 15,",
             request_count, result_count);
    $display("  stop on/off, full classes; pushed %0d full %0d stopping %0d",
             status_seen[ST_PUSHED], status_seen[ST_FULL], status_seen[ST_STOPPING]);
    $display("  bad %0d popped %0d empty %0d",
             status_seen[ST_BAD_CLASS], status_seen[ST_POPPED], status_seen[ST_EMPTY]);
    if (error_count == 0) begin
      $display("three_class_priority_task_queue_tb: done, clean");
    end else begin
      $display("three_class_priority_task_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
